### hdl/pid_with_sign_reset_integrator_core_macros.svh
// Assertion macros for the PID core checker.
`ifndef PID_WITH_SIGN_RESET_INTEGRATOR_CORE_MACROS_SVH
`define PID_WITH_SIGN_RESET_INTEGRATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PWSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked from the next cycle on.
`define PWSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pwsr_pkg.sv
`timescale 1ns / 1ps
package pwsr_pkg;

	localparam int DATA_W = 32;
	localparam int GAIN_W = 24;
	localparam int INTEG_W = 48;
	localparam int ACC_W = 64;
	localparam int FRAC_W = 16;
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_STEPS = 48;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [INTEG_W-1:0] MAX48 = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] MIN48 = {1'b1, {(INTEG_W-1){1'b0}}};

	// register map
	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;
	localparam logic [1:0] REG_CLEAR = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_INTEG,
		S_PTERM,
		S_IHI,
		S_ILO,
		S_DWAIT,
		S_DMUL,
		S_DTERM,
		S_SAT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [DATA_W-1:0] sat32_33(input logic signed [DATA_W:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[DATA_W] != x[DATA_W-1]) begin
			r = x[DATA_W] ? MIN32 : MAX32;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [INTEG_W-1:0] sat48_49(
		input logic signed [INTEG_W:0] x);
		logic signed [INTEG_W-1:0] r;
		if (x[INTEG_W] != x[INTEG_W-1]) begin
			r = x[INTEG_W] ? MIN48 : MAX48;
		end else begin
			r = x[INTEG_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32_64(input logic signed [ACC_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > ACC_W'(MAX32)) begin
			r = MAX32;
		end else if (x < ACC_W'(MIN32)) begin
			r = MIN32;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/pwsr_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier, product registered.
module pwsr_mul import pwsr_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

### hdl/pwsr_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: (diff << 16) / divisor, truncated toward zero,
// quotient saturated to signed 32 bits. One quotient bit per cycle.
module pwsr_div import pwsr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DATA_W:0]    diff,
	input  logic [DATA_W-1:0]         divisor,
	output div_stat_t                 stat,
	output logic signed [DATA_W-1:0]  quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DATA_W:0]      mag;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      trial;
	logic                 ge;

	assign mag = diff[DATA_W] ? DATA_W'(0) - diff : diff;
	assign shifted = {rem_q, quo_q[DIV_STEPS-1]};
	assign trial = shifted - {1'b0, dvs_q};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= diff[DATA_W];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= {mag[DATA_W-1:0], {FRAC_W{1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
	end

	always_comb begin
		if (!neg_q) begin
			quot = (|quo_q[DIV_STEPS-1:DATA_W-1]) ? MAX32 : quo_q[DATA_W-1:0];
		end else if ((|quo_q[DIV_STEPS-1:DATA_W]) ||
			(quo_q[DATA_W-1] && (|quo_q[DATA_W-2:0]))) begin
			quot = MIN32;
		end else begin
			quot = DATA_W'(0) - quo_q[DATA_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/pid_with_sign_reset_integrator_core.sv
`timescale 1ns / 1ps
// PID controller core, signed Q16.16 data with Q8.16 gains. Each request on
// the input channel is one control step: error = target - measured
// (saturated), the 48-bit integral is cleared on an error sign reversal when
// the REG_CLEAR bit is set, then advanced by time_step * error and
// saturated. The derivative is (error - last error) / time_step (zero for a
// zero step) when req_type is 0, or target_rate - measured_rate when it is 1.
// drive = gain_p*e + gain_i*integral + gain_d*derivative, each product floored
// to Q16.16, the sum saturated to 32 bits. The block handles one request at a
// time: in_stall is high from acceptance until the result is loaded into the
// output register, and unless in rate mode or with a zero time step the step
// also waits on the bit-serial divider (48 quotient bits, one per cycle). The
// five products share one registered 33x33 multiplier; all but the gain_d
// product run while the divider works. The output register lets the next
// request in while a result still waits on out_stall. Configuration is
// always ready and must be written only while the block is idle.
module pid_with_sign_reset_integrator_core import pwsr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic signed [DATA_W-1:0]  measured,
	input  logic signed [DATA_W-1:0]  target,
	input  logic signed [DATA_W-1:0]  measured_rate,
	input  logic signed [DATA_W-1:0]  target_rate,
	input  logic [DATA_W-1:0]         time_step,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  drive
);

	state_t state_q, state_d;

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic                      clear_q;

	// controller state
	logic signed [DATA_W-1:0]  last_error_q;
	logic signed [INTEG_W-1:0] integ_q;

	// per-request working registers
	logic signed [DATA_W-1:0]  e_q;
	logic signed [DATA_W-1:0]  rdiff_q;
	logic signed [DATA_W-1:0]  deriv_q;
	logic [DATA_W-1:0]         ts_q;
	logic                      mode_q;
	logic                      need_div_q;
	logic signed [ACC_W-1:0]   acc_q;

	// result register
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  drive_q;

	// shared multiplier and divider
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   prod_fl;
	logic signed [ACC_W-1:0]   prod_full;
	logic signed [INTEG_W-1:0] prod_integ;
	logic                      div_start;
	div_stat_t                 div_stat;
	logic signed [DATA_W-1:0]  div_quot;

	logic                      accept;
	logic                      slot_free;
	logic                      need_div;
	logic                      sign_flip;
	logic signed [DATA_W:0]    ediff;

	assign accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign need_div = !mode_q && (ts_q != '0);
	assign sign_flip = clear_q && (last_error_q != '0) && (e_q != '0) &&
		(e_q[DATA_W-1] != last_error_q[DATA_W-1]);
	assign ediff = {e_q[DATA_W-1], e_q} - {last_error_q[DATA_W-1], last_error_q};

	// product floored to Q16.16, full product, and the Q32.16 integration step
	assign prod_fl = {{(ACC_W-PROD_W+FRAC_W){prod_s1[PROD_W-1]}}, prod_s1[PROD_W-1:FRAC_W]};
	assign prod_full = prod_s1[ACC_W-1:0];
	assign prod_integ = prod_s1[INTEG_W+FRAC_W-1:FRAC_W];

	pwsr_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (prod_s1)
	);

	pwsr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.diff    (ediff),
		.divisor (ts_q),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_SETUP;
			S_SETUP: state_d = S_INTEG;
			S_INTEG: state_d = S_PTERM;
			S_PTERM: state_d = S_IHI;
			S_IHI:   state_d = S_ILO;
			S_ILO:   state_d = S_DWAIT;
			S_DWAIT: if (!need_div_q || div_stat.done) state_d = S_DMUL;
			S_DMUL:  state_d = S_DTERM;
			S_DTERM: state_d = S_SAT;
			S_SAT:   if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands, divider start, request stall
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_SETUP: begin
				mul_a = {1'b0, ts_q};
				mul_b = MUL_W'(e_q);
				div_start = need_div;
			end
			S_INTEG: begin
				mul_a = MUL_W'(gain_p_q);
				mul_b = MUL_W'(e_q);
			end
			S_PTERM: begin
				// upper integral half is signed
				mul_a = MUL_W'(gain_i_q);
				mul_b = MUL_W'($signed(integ_q[INTEG_W-1:FRAC_W]));
			end
			S_IHI: begin
				mul_a = MUL_W'(gain_i_q);
				mul_b = {{(MUL_W-FRAC_W){1'b0}}, integ_q[FRAC_W-1:0]};
			end
			S_DMUL: begin
				mul_a = MUL_W'(gain_d_q);
				mul_b = MUL_W'(deriv_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			clear_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_CLEAR:  clear_q <= cfg_data[0];
				default:    clear_q <= clear_q;
			endcase
		end
	end

	// controller state: last error and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			integ_q <= '0;
		end else begin
			case (state_q)
				S_SETUP: begin
					last_error_q <= e_q;
					if (sign_flip) integ_q <= '0;
				end
				S_INTEG: begin
					integ_q <= sat48_49({integ_q[INTEG_W-1], integ_q} +
						{prod_integ[INTEG_W-1], prod_integ});
				end
				default: begin
					integ_q <= integ_q;
				end
			endcase
		end
	end

	// per-request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					e_q <= sat32_33({target[DATA_W-1], target} -
						{measured[DATA_W-1], measured});
					rdiff_q <= sat32_33({target_rate[DATA_W-1], target_rate} -
						{measured_rate[DATA_W-1], measured_rate});
					ts_q <= time_step;
					mode_q <= req_type;
				end
			end
			S_SETUP: begin
				deriv_q <= mode_q ? rdiff_q : '0;
				need_div_q <= need_div;
			end
			S_PTERM: acc_q <= prod_fl;
			S_IHI:   acc_q <= acc_q + prod_full;
			S_ILO:   acc_q <= acc_q + prod_fl;
			S_DWAIT: if (need_div_q) deriv_q <= div_quot;
			S_DTERM: acc_q <= acc_q + prod_fl;
			default: acc_q <= acc_q;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_SAT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SAT && slot_free) begin
			drive_q <= sat32_64(acc_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive = drive_q;

endmodule

### hdl/pwsr_checker.sv
`timescale 1ns / 1ps
`include "pid_with_sign_reset_integrator_core_macros.svh"
module pwsr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall
);

	// a result held back stays offered
	`PWSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// a step occupies the block for at least its setup and integration cycles
	`PWSR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall ##1 in_stall, "request taken while busy")

	// the block frees up only by loading a result
	`PWSR_ASSERT_NOW(a_ready_with_result, $fell(in_stall), out_valid, "ready without a result")

	// a result is never offered at the edge right after a request on an empty output
	`PWSR_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && (!out_valid || !out_stall), !out_valid, "result too early")

endmodule

bind pid_with_sign_reset_integrator_core pwsr_checker u_pwsr_checker (.*);

### tb/pid_drive_checker.sv
`timescale 1ns / 1ps
// Watches the config, request and result channels, predicts drive for each
// accepted request and compares it with the results in order.
module pid_drive_checker import pwsr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      req_type,
	input  logic signed [DATA_W-1:0]  measured,
	input  logic signed [DATA_W-1:0]  target,
	input  logic signed [DATA_W-1:0]  measured_rate,
	input  logic signed [DATA_W-1:0]  target_rate,
	input  logic [DATA_W-1:0]         time_step,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [DATA_W-1:0]  drive,
	output int unsigned               outstanding,
	output int                        fail_count
);

	// predictor copy of the registers and loop state
	logic signed [GAIN_W-1:0]  kp;
	logic signed [GAIN_W-1:0]  ki;
	logic signed [GAIN_W-1:0]  kd;
	logic                      clear_flip;
	logic signed [DATA_W-1:0]  prev_err;
	logic signed [INTEG_W-1:0] err_sum;

	logic signed [DATA_W-1:0]  expected_drive[$];
	logic signed [DATA_W-1:0]  want;
	int                        errors;

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_drive(
		input logic rate_mode,
		input logic signed [DATA_W-1:0] meas,
		input logic signed [DATA_W-1:0] targ,
		input logic signed [DATA_W-1:0] mrate,
		input logic signed [DATA_W-1:0] trate,
		input logic [DATA_W-1:0] step);
		longint e, dv, ts, pt, it, dt, ihi, ilo, acc;
		ts = longint'(step);
		e = clamp(longint'(targ) - longint'(meas), longint'(MIN32), longint'(MAX32));
		// sign reversal clears the integral before accumulation
		if (clear_flip && prev_err != 0 && e != 0 && ((e < 0) != (prev_err < 0))) begin
			err_sum = '0;
		end
		acc = longint'(err_sum) + ((ts * e) >>> FRAC_W);
		err_sum = INTEG_W'(clamp(acc, longint'(MIN48), longint'(MAX48)));
		if (rate_mode) begin
			dv = longint'(trate) - longint'(mrate);
		end else if (ts == 0) begin
			dv = 0;
		end else begin
			dv = ((e - longint'(prev_err)) * 65536) / ts;
		end
		dv = clamp(dv, longint'(MIN32), longint'(MAX32));
		prev_err = DATA_W'(e);
		pt = (longint'(kp) * e) >>> FRAC_W;
		dt = (longint'(kd) * dv) >>> FRAC_W;
		// exact gain_i * integral >> 16 via split halves
		ihi = longint'(err_sum) >>> FRAC_W;
		ilo = longint'(err_sum) - ihi * 65536;
		it = longint'(ki) * ihi + ((longint'(ki) * ilo) >>> FRAC_W);
		return DATA_W'(clamp(pt + it + dt, longint'(MIN32), longint'(MAX32)));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			clear_flip = 1'b1;
			prev_err = '0;
			err_sum = '0;
			expected_drive.delete();
			errors = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_P: kp = cfg_data;
					REG_GAIN_I: ki = cfg_data;
					REG_GAIN_D: kd = cfg_data;
					REG_CLEAR:  clear_flip = cfg_data[0];
					default: ;
				endcase
			end
			// results first: anything leaving now belongs to an older request
			if (out_valid && !out_stall) begin
				if (expected_drive.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual drive %0d",
						$time, drive);
				end else begin
					want = expected_drive.pop_front();
					if (want !== drive) begin
						errors++;
						$display("%0t: drive mismatch, expected %0d, actual %0d",
							$time, want, drive);
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_drive.push_back(predict_drive(req_type, measured, target,
					measured_rate, target_rate, time_step));
			end
			outstanding <= expected_drive.size();
			fail_count <= errors;
		end
	end

endmodule

### tb/pid_with_sign_reset_integrator_core_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the PID core. The checker beside the block does
// all prediction and comparison; this module only feeds requests, writes
// the configuration registers between phases and drives the result-side stall.
module pid_with_sign_reset_integrator_core_tb;
	import pwsr_pkg::*;

	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 210;
	localparam int MAX_GAP    = 40;
	localparam int LONG_HOLD  = 300;   // result-side hold-off, cycles
	localparam int TAIL       = 60;    // > one slow request

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [GAIN_W-1:0]         cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      req_type;
	logic signed [DATA_W-1:0]  measured;
	logic signed [DATA_W-1:0]  target;
	logic signed [DATA_W-1:0]  measured_rate;
	logic signed [DATA_W-1:0]  target_rate;
	logic [DATA_W-1:0]         time_step;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  drive;

	int unsigned               outstanding;
	int                        fail_count;

	// idle percentages for the current phase, read by both driving processes
	int                        tx_pct = 0;
	int                        rx_pct = 0;
	// long hold-offs: asked by the stimulus, served by the stall process
	int                        holds_asked = 0;
	int                        holds_done = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pid_with_sign_reset_integrator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.measured      (measured),
		.target        (target),
		.measured_rate (measured_rate),
		.target_rate   (target_rate),
		.time_step     (time_step),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive         (drive)
	);

	pid_drive_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.measured      (measured),
		.target        (target),
		.measured_rate (measured_rate),
		.target_rate   (target_rate),
		.time_step     (time_step),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive         (drive),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	// Offer one request after a random gap and hold it until accepted.
	// Valid stays high when the next request follows with no gap, so the
	// line never gets two updates in one step.
	task automatic push_request(input logic rt, input logic signed [DATA_W-1:0] m,
		input logic signed [DATA_W-1:0] t, input logic signed [DATA_W-1:0] mr,
		input logic signed [DATA_W-1:0] tr, input logic [DATA_W-1:0] ts);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		measured <= m;
		target <= t;
		measured_rate <= mr;
		target_rate <= tr;
		time_step <= ts;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, wait for every expected result, then let the block go idle.
	// outstanding is updated by nonblocking assignment, so the value seen
	// after an edge covers every handshake up to the previous one.
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all four registers back to back; only bit 0 of the last matters.
	task automatic configure(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
		input logic [GAIN_W-1:0] gd, input logic [GAIN_W-1:0] clr_word);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_CLEAR, clr_word);
		cfg_valid <= 1'b0;
	endtask

	// Q16.16 value: extremes, full range, or small and moderate magnitudes.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: return MAX32;
					1: return MIN32;
					2: return '0;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			1, 2: return $urandom;
			3, 4: return 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
			default: return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_step();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return 32'($urandom_range(32'h0002_0000, 1));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(input bit modest);
		if (modest) begin
			return 24'($urandom_range(32'h0008_0000) - 32'h0004_0000);
		end
		return 24'($urandom);
	endfunction

	// Mostly a tracking loop: measured sits near target so the error is small
	// and changes sign often, which exercises the integrator clear. The rest
	// is unrelated measured values, giving large and saturating errors.
	task automatic send_random_request();
		logic signed [DATA_W-1:0] t, m;
		t = pick_value();
		if ($urandom_range(3) == 0) begin
			m = pick_value();
		end else begin
			m = t + (32'($urandom_range(32'h0004_0000)) - 32'h0002_0000);
		end
		push_request(1'($urandom_range(1)), m, t, pick_value(), pick_value(), pick_step());
	endtask

	// Result side: random stall at the phase rate, or a long counted hold-off
	// when one is asked, while the sender keeps offering requests.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < rx_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("pid_with_sign_reset_integrator_core test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		measured = '0;
		target = '0;
		measured_rate = '0;
		target_rate = '0;
		time_step = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gains give zero drive but state still moves
		push_request(1'b0, 32'h0001_0000, 32'h0005_0000, '0, '0, 32'h0001_0000);
		push_request(1'b1, '0, 32'hfff0_0000, 32'h0000_1000, 32'h0000_3000, '0);
		settle(4);

		// directed: unity P, half I, quarter D, clear on reversal
		configure(24'h01_0000, 24'h00_8000, 24'h00_4000, 24'h00_0001);
		push_request(1'b0, '0, '0, '0, '0, '0);
		// error saturates high with the longest step; repeats drive the
		// integral into its upper limit
		push_request(1'b0, MIN32, MAX32, '0, '0, '1);
		push_request(1'b0, MIN32, MAX32, '0, '0, '1);
		push_request(1'b0, MIN32, MAX32, '0, '0, '1);
		// reversal to the most negative error clears the integral, then it
		// saturates low
		push_request(1'b0, MAX32, MIN32, '0, '0, '1);
		push_request(1'b0, MAX32, MIN32, '0, '0, '1);
		// one-LSB step with a big error jump: derivative saturates
		push_request(1'b0, '0, 32'h4000_0000, '0, '0, 32'd1);
		// zero step with a nonzero error: no derivative
		push_request(1'b0, 32'h0001_0000, '0, '0, '0, '0);
		// error back to zero, then one LSB either side of zero
		push_request(1'b0, 32'h1234_5678, 32'h1234_5678, '0, '0, 32'h0001_0000);
		push_request(1'b0, '0, 32'd1, '0, '0, 32'h0001_0000);
		push_request(1'b0, '0, '1, '0, '0, 32'h0001_0000);
		// rate mode at the rails, both ways, then an ordinary one
		push_request(1'b1, '0, '0, MIN32, MAX32, '0);
		push_request(1'b1, '0, '0, MAX32, MIN32, '0);
		push_request(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_8000,
			32'h0000_4000);
		// fractional quotients, positive and negative numerator
		push_request(1'b0, 32'h0003_0000, '0, '0, '0, 32'h0003_0000);
		push_request(1'b0, 32'hfffd_0001, '0, '0, '0, 32'h0007_0000);
		push_request(1'b0, '0, 32'h7fff_0000, '0, '0, 32'hffff_ffff);
		settle(4);

		for (int p = 1; p <= PHASES; p++) begin
			case ((p - 1) % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 82; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 82; end
				default: begin tx_pct = 21; rx_pct = 21; end
			endcase
			case (p)
				1: configure(24'h7f_ffff, 24'h7f_ffff, 24'h7f_ffff, 24'h00_0000);
				2: configure(24'h80_0000, 24'h80_0000, 24'h80_0000, 24'hff_ffff);
				3: configure(24'h00_0000, 24'h7f_ffff, 24'h00_0000, 24'h00_0000);
				default: configure(pick_gain(p % 2 == 0), pick_gain(p % 2 == 0),
					pick_gain(p % 2 == 0), 24'($urandom));
			endcase
			// back pressure: results held off while requests keep coming
			if ((p - 1) % 4 == 0) begin
				holds_asked++;
			end
			for (int k = 0; k < PHASE_REQS; k++) begin
				send_random_request();
			end
			settle(4);
		end

		settle(TAIL);
		if (fail_count == 0 && outstanding == 0) begin
			$display("pid_with_sign_reset_integrator_core test passed");
		end else begin
			$display("pid_with_sign_reset_integrator_core test failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/pwsr_pkg.sv
hdl/pwsr_mul.sv
hdl/pwsr_div.sv
hdl/pid_with_sign_reset_integrator_core.sv
hdl/pwsr_checker.sv
tb/pid_drive_checker.sv
tb/pid_with_sign_reset_integrator_core_tb.sv
